// ===== rtl/sorted_priority_queue_unit_assert.svh =====
// Assertion macros used by the checker file.
// Each one samples on the rising edge of clk and stays quiet while rst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

    localparam int KEY_W     = 8;
    localparam int ID_W      = 16;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 5;
    localparam int DEPTH_DEF = 16;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic             cmd;
        logic [ID_W-1:0]  item_id;
        logic [KEY_W-1:0] prio_key;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     out_id;
        logic [KEY_W-1:0]    out_key;
        logic [FILL_W-1:0]   fill_count;
    } out_beat_t;

    // One queue slot
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } entry_t;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } cell_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
module spq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic               clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]   count,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_gt,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               gt
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            occupied;
    logic            at_tail;
    logic            moves;

    // Slot is live below the count; the first free slot is the tail
    assign occupied = count > CNT_W'(IDX);
    assign at_tail  = count == CNT_W'(IDX);
    assign gt       = occupied && (entry_reg.key > ctrl.key);
    assign moves    = gt || at_tail;

    // Insert: shift right past larger keys, or take the new beat at its slot.
    // Remove: pull from the right neighbor.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && moves)
        begin
            if (left_gt)
            begin
                entry_next = left_entry;
            end
            else
            begin
                entry_next.key = ctrl.key;
                entry_next.id  = ctrl.id;
            end
        end
        else if (ctrl.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// Channel | Direction | Payload            | Handshake
// in      | input     | spq_pkg::in_beat_t  | in_valid / in_ready
// out     | output    | spq_pkg::out_beat_t | out_valid / out_ready
//
// For each beat, every cell compares its key with the broadcast key and
// shifts in the same cycle, and the result lands in the output register.
// A new beat is taken whenever the output register is empty or being drained.
// rst_n clears the entry count and the output valid; cell contents need no reset.
// A stall on out holds the result and stops input until it drains.
module sorted_priority_queue_unit #(
    parameter int QUEUE_DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  spq_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output spq_pkg::out_beat_t out_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    spq_pkg::out_beat_t  out_data_reg;
    spq_pkg::out_beat_t  out_data_next;
    spq_pkg::cell_ctrl_t ctrl;
    spq_pkg::entry_t     cell_entry [QUEUE_DEPTH];
    logic                cell_gt    [QUEUE_DEPTH];
    logic                accept;
    logic                full;
    logic                empty;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;

    // Broadcast command to the row
    assign ctrl.ins = accept && (in_data.cmd == spq_pkg::CMD_INSERT) && !full;
    assign ctrl.rem = accept && (in_data.cmd == spq_pkg::CMD_REMOVE) && !empty;
    assign ctrl.key = in_data.prio_key;
    assign ctrl.id  = in_data.item_id;

    // Row of cells, head at index zero
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        spq_pkg::entry_t left_entry;
        spq_pkg::entry_t right_entry;
        logic            left_gt;

        if (i == 0)
        begin : g_head
            assign left_entry = '0;
            assign left_gt    = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = '0;
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_entry  (left_entry),
            .left_gt     (left_gt),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    // Build the result beat
    always_comb
    begin
        count_next               = count_reg;
        out_data_next.status     = spq_pkg::STAT_DONE;
        out_data_next.out_id     = '0;
        out_data_next.out_key    = '0;
        if (in_data.cmd == spq_pkg::CMD_INSERT)
        begin
            if (full)
            begin
                out_data_next.status = spq_pkg::STAT_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                out_data_next.status = spq_pkg::STAT_EMPTY;
            end
            else
            begin
                count_next            = count_reg - CNT_W'(1);
                out_data_next.out_id  = cell_entry[0].id;
                out_data_next.out_key = cell_entry[0].key;
            end
        end
        out_data_next.fill_count = spq_pkg::FILL_W'(count_next);
    end

    // Advance count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/spq_checker.sv =====
`include "sorted_priority_queue_unit_assert.svh"

module spq_checker #(
    parameter int QUEUE_DEPTH = spq_pkg::DEPTH_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input spq_pkg::out_beat_t out_data
);

    logic in_fire;
    logic out_stall;
    logic full_beat;
    logic full_ok;
    logic empty_beat;
    logic empty_ok;

    // Decode the handshakes and the special result beats
    assign in_fire    = in_valid && in_ready;
    assign out_stall  = out_valid && !out_ready;
    assign full_beat  = out_valid && (out_data.status == spq_pkg::STAT_FULL);
    assign full_ok    = (out_data.fill_count == spq_pkg::FILL_W'(QUEUE_DEPTH))
                        && (out_data.out_id == '0) && (out_data.out_key == '0);
    assign empty_beat = out_valid && (out_data.status == spq_pkg::STAT_EMPTY);
    assign empty_ok   = (out_data.fill_count == '0) && (out_data.out_id == '0)
                        && (out_data.out_key == '0);

    // A stalled result beat stays up
    `SPQ_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "out beat dropped while stalled")

    // Every accepted input beat yields a result beat in the next cycle
    `SPQ_ASSERT_NEXT(a_in_to_out, in_fire, out_valid, "no result after accepted beat")

    // A refused insert reports a full queue
    `SPQ_ASSERT_IMPL(a_full_count, full_beat, full_ok, "full status with wrong count")

    // A remove on empty reports nothing held and no entry
    `SPQ_ASSERT_IMPL(a_empty_zero, empty_beat, empty_ok, "empty status with data")

endmodule

bind sorted_priority_queue_unit spq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
